// ----- sv/ezr_pkg.sv -----
// Package for the Z-Y-X Euler rotation matrix block.
// Holds the beat structs, Q30 constants and the CORDIC arctangent table.
// Depends on nothing.
package ezr_pkg;

  localparam int QF = 30;
  localparam int IW = 36;
  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;
  localparam logic signed [IW-1:0] PI_Q = 36'sd3373259426;
  localparam logic signed [IW-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [IW-1:0] TWO_PI_Q = 36'sd6746518852;
  localparam logic signed [IW-1:0] CORDIC_K = 36'sd652032874;

  typedef logic signed [IW-1:0] q_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] r11;
    logic signed [ENTRY_BITS-1:0] r12;
    logic signed [ENTRY_BITS-1:0] r13;
    logic signed [ENTRY_BITS-1:0] r21;
    logic signed [ENTRY_BITS-1:0] r22;
    logic signed [ENTRY_BITS-1:0] r23;
    logic signed [ENTRY_BITS-1:0] r31;
    logic signed [ENTRY_BITS-1:0] r32;
    logic signed [ENTRY_BITS-1:0] r33;
  } out_beat_t;

  function automatic q_t atan_q(input int i);
    q_t r;
    begin
      case (i)
        0: r = 36'sd843314857;
        1: r = 36'sd497837829;
        2: r = 36'sd263043837;
        3: r = 36'sd133525159;
        4: r = 36'sd67021687;
        5: r = 36'sd33543516;
        6: r = 36'sd16775851;
        7: r = 36'sd8388437;
        8: r = 36'sd4194283;
        9: r = 36'sd2097149;
        default: r = (i < 30) ? (q_t'(1) <<< (30 - i)) : '0;
      endcase
      return r;
    end
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*IW-1:0] p;
    begin
      p = a * b + (72'sd1 <<< (QF - 1));
      return q_t'(p >>> QF);
    end
  endfunction

endpackage

// ----- sv/ezr_cordic.sv -----
// One CORDIC sine/cosine lane: range reduction stage then one register per step.
// Depends on ezr_pkg.
module ezr_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int STEPS = 14
) (
  input  logic clk,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output ezr_pkg::q_t sin_q,
  output ezr_pkg::q_t cos_q
);
  import ezr_pkg::*;

  q_t a0, a1, ared;
  logic flip_c;
  q_t xs [0:STEPS];
  q_t ys [0:STEPS];
  q_t zs [0:STEPS];
  logic fl [0:STEPS];

  always_comb begin
    a0 = q_t'(angle) <<< (QF - (ANGLE_BITS - 4));
    a1 = a0;
    if (a0 > PI_Q) a1 = a0 - TWO_PI_Q;
    if (a1 > PI_Q) a1 = a1 - TWO_PI_Q;
    if (a0 < -PI_Q) a1 = a0 + TWO_PI_Q;
    if (a1 < -PI_Q) a1 = a1 + TWO_PI_Q;
    flip_c = 1'b0;
    ared = a1;
    if (a1 > HALF_PI_Q) begin
      ared = a1 - PI_Q;
      flip_c = 1'b1;
    end else if (a1 < -HALF_PI_Q) begin
      ared = a1 + PI_Q;
      flip_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= CORDIC_K;
    ys[0] <= '0;
    zs[0] <= ared;
    fl[0] <= flip_c;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q(i);
      end
      fl[i+1] <= fl[i];
    end
  end

  assign cos_q = fl[STEPS] ? -xs[STEPS] : xs[STEPS];
  assign sin_q = fl[STEPS] ? -ys[STEPS] : ys[STEPS];
endmodule

// ----- sv/ezr_merge.sv -----
// Merging stage: forms the nine matrix entries from the three lanes' results.
// Two registered product stages, then a registered rounding and saturation stage.
// Depends on ezr_pkg.
module ezr_merge #(
  parameter int ENTRY_BITS = 16
) (
  input  logic clk,
  input  ezr_pkg::q_t sx, cx, sy, cy, sz, cz,
  output logic signed [9*ENTRY_BITS-1:0] entries
);
  import ezr_pkg::*;

  localparam int SH = QF + 2 - ENTRY_BITS;

  q_t czsy, szsy, p11, p21, p32, p33, nsy, szcx, szsx, czcx, czsx;
  q_t sx1, cx1;
  q_t e [0:8];

  function automatic logic signed [ENTRY_BITS-1:0] to_entry(input q_t v);
    logic signed [IW:0] t;
    logic signed [IW:0] lim;
    begin
      lim = (IW+1)'(1) <<< (ENTRY_BITS - 2);
      t = {v[IW-1], v};
      if (SH > 0) t = (t + ((IW+1)'(1) <<< (SH - 1))) >>> SH;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t[ENTRY_BITS-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    czsy <= qmul(cz, sy);
    szsy <= qmul(sz, sy);
    p11 <= qmul(cz, cy);
    p21 <= qmul(sz, cy);
    p32 <= qmul(cy, sx);
    p33 <= qmul(cy, cx);
    nsy <= -sy;
    szcx <= qmul(sz, cx);
    szsx <= qmul(sz, sx);
    czcx <= qmul(cz, cx);
    czsx <= qmul(cz, sx);
    sx1 <= sx;
    cx1 <= cx;
    e[0] <= p11;
    e[1] <= qmul(czsy, sx1) - szcx;
    e[2] <= qmul(czsy, cx1) + szsx;
    e[3] <= p21;
    e[4] <= qmul(szsy, sx1) + czcx;
    e[5] <= qmul(szsy, cx1) - czsx;
    e[6] <= nsy;
    e[7] <= p32;
    e[8] <= p33;
    for (int k = 0; k < 9; k++)
      entries[(8-k)*ENTRY_BITS +: ENTRY_BITS] <= to_entry(e[k]);
  end
endmodule

// ----- sv/euler_zyx_rotation_matrix.sv -----
// Top level of the Z-Y-X Euler rotation matrix block.
// Depends on ezr_pkg, ezr_cordic and ezr_merge.
// The block takes one angle triple every cycle (busy is never high) and
// delivers each result, marked by done for one cycle, after it has passed
// the range reduction register and the CORDIC step pipeline in each of the
// three lanes and then the three merge stages. The receiver cannot stall.
module euler_zyx_rotation_matrix #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ezr_pkg::in_beat_t in_beat,
  output logic done,
  output ezr_pkg::out_beat_t out_beat
);
  import ezr_pkg::*;

  localparam int LAT = CORDIC_STEPS + 4;

  q_t sx, cx, sy, cy, sz, cz;
  logic signed [9*ENTRY_BITS-1:0] entries;
  logic [LAT-1:0] vld;

  assign busy = 1'b0;

  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_x (
    .clk(clk), .angle(in_beat.angle_x), .sin_q(sx), .cos_q(cx));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_y (
    .clk(clk), .angle(in_beat.angle_y), .sin_q(sy), .cos_q(cy));
  ezr_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_z (
    .clk(clk), .angle(in_beat.angle_z), .sin_q(sz), .cos_q(cz));

  ezr_merge #(.ENTRY_BITS(ENTRY_BITS)) u_merge (
    .clk(clk), .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .entries(entries));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];
  assign out_beat = out_beat_t'(entries);

`ifndef SYNTHESIS
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[LAT-2]))
    else $error("done without earlier beat");
  a_r31_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_beat.r31 <= 16'sd16384 && out_beat.r31 >= -16'sd16384))
    else $error("r31 out of range");
`endif
endmodule
